>>> rtl/dats_pkg.sv
`timescale 1ns / 1ps

package dats_pkg;

    localparam int ADDR_W  = 4;
    localparam int TIME_W  = 11;
    localparam int DELTA_W = 13;

    localparam logic [9:0]  MAX_GRAMS    = 10'd500;
    localparam logic [4:0]  LAST_HOUR    = 5'd23;
    localparam logic [5:0]  LAST_MINUTE  = 6'd59;
    localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
    localparam logic signed [DELTA_W-1:0] DAY_MINUTES = 13'sd1440;

    localparam logic [1:0] REG_MEAL_COUNT  = 2'd0;
    localparam logic [1:0] REG_WINDOW      = 2'd1;
    localparam logic [1:0] REG_MAX_SECONDS = 2'd2;

    localparam logic [3:0]  MEAL_COUNT_RST  = 4'd0;
    localparam logic [10:0] WINDOW_RST      = 11'd15;
    localparam logic [15:0] MAX_SECONDS_RST = 16'd60;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DUE   = 2'd1,
        KIND_NEXT  = 2'd2,
        KIND_MARK  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_TIME     = 3'd1,
        ST_NO_AMOUNT    = 3'd2,
        ST_GRAMS_HIGH   = 3'd3,
        ST_SECONDS_HIGH = 3'd4,
        ST_BAD_INDEX    = 3'd5
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  entry_index;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [9:0]  grams;
        logic [15:0] seconds;
        logic [4:0]  day_of_month;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [2:0]  meal_index;
        logic [4:0]  meal_hour;
        logic [5:0]  meal_minute;
        logic [8:0]  meal_grams;
        logic [15:0] meal_seconds;
    } t_rsp;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [8:0]  grams;
        logic [15:0] seconds;
    } t_entry;

    function automatic logic [TIME_W-1:0] minutes_of(input logic [4:0] hour,
                                                     input logic [5:0] minute);
        return TIME_W'(hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(minute);
    endfunction

endpackage

>>> rtl/daily_alarm_table_scheduler_top.sv
`timescale 1ns / 1ps
// Writes and marks pass through the execute and done states; the response is registered in done.
// Queries also scan the n active entries between execute and done, n being the active entry count.
// One request is in flight at a time: the request stall holds from acceptance until the
// response has been registered and the block is back in idle.
// The scan reads one table entry per cycle from the table memory, whose read data is registered.
// Reset is synchronous and active low; table entries read as zero until written.

module daily_alarm_table_scheduler_top #(
    parameter int MAX_MEALS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_stall,
    input  dats_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    output dats_pkg::t_rsp              o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dats_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import dats_pkg::*;

    localparam int IDX_W = (MAX_MEALS > 1) ? $clog2(MAX_MEALS) : 1;
    localparam int CNT_W = $clog2(MAX_MEALS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                     r_state;
    t_req                       r_req;
    t_rsp                       r_res;
    t_rsp                       r_rsp;
    logic                       r_rsp_valid;
    logic [TIME_W-1:0]          r_now;
    logic [CNT_W-1:0]           r_addr;
    logic [IDX_W-1:0]           r_pidx;
    logic                       r_pend;
    logic                       r_found;
    logic signed [DELTA_W-1:0]  r_best;
    logic [MAX_MEALS-1:0]       r_vld;
    logic [MAX_MEALS-1:0]       r_mask;
    logic [4:0]                 r_mask_day;
    logic [3:0]                 r_meal_count;
    logic [10:0]                r_window;
    logic [15:0]                r_max_seconds;

    logic                       req_take;
    logic [3:0]                 active_n;
    logic                       issue;
    logic                       idx_ok;
    t_status                    wr_status;
    logic                       ram_we;
    logic [IDX_W-1:0]           req_idx;
    logic [35:0]                rd_data;
    t_entry                     wr_entry;
    t_entry                     rd_entry;
    logic [TIME_W-1:0]          at;
    logic                       due_hit;
    logic signed [DELTA_W-1:0]  delta;
    logic                       next_hit;
    logic                       take_hit;
    logic [MAX_MEALS-1:0]       mark_bit;
    logic                       cfg_wr;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign o_req_stall = (r_state != S_IDLE);
    assign req_take    = i_req_valid && !o_req_stall;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meal_count  <= MEAL_COUNT_RST;
            r_window      <= WINDOW_RST;
            r_max_seconds <= MAX_SECONDS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MEAL_COUNT:  r_meal_count  <= pwdata[3:0];
                REG_WINDOW:      r_window      <= pwdata[10:0];
                REG_MAX_SECONDS: r_max_seconds <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MEAL_COUNT:  prdata = 32'(r_meal_count);
            REG_WINDOW:      prdata = 32'(r_window);
            REG_MAX_SECONDS: prdata = 32'(r_max_seconds);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        active_n = (r_meal_count > 4'(MAX_MEALS)) ? 4'(MAX_MEALS) : r_meal_count;
        issue    = (4'(r_addr) < active_n);
        idx_ok   = (r_req.entry_index < 4'(MAX_MEALS));
        req_idx  = r_req.entry_index[IDX_W-1:0];

        if (!idx_ok) begin
            wr_status = ST_BAD_INDEX;
        end else if (r_req.hour > LAST_HOUR || r_req.minute > LAST_MINUTE) begin
            wr_status = ST_BAD_TIME;
        end else if (r_req.grams == '0 && r_req.seconds == '0) begin
            wr_status = ST_NO_AMOUNT;
        end else if (r_req.grams > MAX_GRAMS) begin
            wr_status = ST_GRAMS_HIGH;
        end else if (r_req.seconds > r_max_seconds) begin
            wr_status = ST_SECONDS_HIGH;
        end else begin
            wr_status = ST_OK;
        end

        ram_we   = (r_state == S_EXEC) && (r_req.kind == KIND_WRITE) && (wr_status == ST_OK);
        wr_entry = '{hour: r_req.hour, minute: r_req.minute,
                     grams: r_req.grams[8:0], seconds: r_req.seconds};

        mark_bit          = '0;
        mark_bit[req_idx] = 1'b1;

        rd_entry = r_vld[r_pidx] ? t_entry'(rd_data) : '0;
        at       = minutes_of(rd_entry.hour, rd_entry.minute);
        due_hit  = !r_found && !r_mask[r_pidx] && (r_now >= at) && ((r_now - at) <= r_window);
        delta    = $signed({2'b00, at}) - $signed({2'b00, r_now});
        if (delta <= 0) begin
            delta = delta + DAY_MINUTES;
        end
        next_hit = !r_found || (delta < r_best);
        take_hit = r_pend && (((r_req.kind == KIND_DUE) && due_hit) ||
                              ((r_req.kind == KIND_NEXT) && next_hit));
    end

    dats_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_MEALS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (req_idx),
        .i_wdata (wr_entry),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_vld       <= '0;
            r_mask      <= '0;
            r_mask_day  <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (r_rsp_valid && !i_rsp_stall && r_state != S_DONE) begin
                r_rsp_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_req   <= i_req;
                        r_now   <= minutes_of(i_req.hour, i_req.minute);
                        r_res   <= '0;
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req.kind)
                        KIND_WRITE: begin
                            r_res.status <= wr_status;
                            if (wr_status == ST_OK) begin
                                r_vld[req_idx] <= 1'b1;
                                r_mask         <= '0;
                                r_mask_day     <= '0;
                            end
                            r_state <= S_DONE;
                        end
                        KIND_MARK: begin
                            if (!idx_ok) begin
                                r_res.status <= ST_BAD_INDEX;
                            end else if (r_req.day_of_month != r_mask_day) begin
                                r_mask_day <= r_req.day_of_month;
                                r_mask     <= mark_bit;
                            end else begin
                                r_mask <= r_mask | mark_bit;
                            end
                            r_state <= S_DONE;
                        end
                        KIND_DUE: begin
                            if (active_n != '0 && r_req.day_of_month != r_mask_day) begin
                                r_mask_day <= r_req.day_of_month;
                                r_mask     <= '0;
                            end
                            r_state <= S_SCAN;
                        end
                        KIND_NEXT: begin
                            r_state <= S_SCAN;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_SCAN: begin
                    if (take_hit) begin
                        r_found            <= 1'b1;
                        r_best             <= delta;
                        r_res.found        <= 1'b1;
                        r_res.meal_index   <= 3'(r_pidx);
                        r_res.meal_hour    <= rd_entry.hour;
                        r_res.meal_minute  <= rd_entry.minute;
                        r_res.meal_grams   <= rd_entry.grams;
                        r_res.meal_seconds <= rd_entry.seconds;
                    end
                    r_pend <= issue;
                    r_pidx <= r_addr[IDX_W-1:0];
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_rsp_valid || !i_rsp_stall) begin
                        r_rsp       <= r_res;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/dats_ram.sv
`timescale 1ns / 1ps

module dats_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/dats_chk.sv
`timescale 1ns / 1ps

module dats_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        o_req_stall,
    input  logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    input  dats_pkg::t_rsp              o_rsp
);

    import dats_pkg::*;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("A new request was taken while one was in progress.");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("A stalled response changed or was dropped.");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.found |-> o_rsp.meal_index == '0 && o_rsp.meal_hour == '0 &&
        o_rsp.meal_minute == '0 && o_rsp.meal_grams == '0 && o_rsp.meal_seconds == '0)
        else $error("A response without a match carries entry fields.");

    a_error_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |-> !o_rsp.found)
        else $error("A failed request reported a match.");

    a_found_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.found |-> o_rsp.meal_hour <= LAST_HOUR &&
        o_rsp.meal_minute <= LAST_MINUTE && 10'(o_rsp.meal_grams) <= MAX_GRAMS)
        else $error("A matched entry holds values that a write would reject.");

endmodule

bind daily_alarm_table_scheduler_top dats_chk u_dats_chk (.*);

>>> tb/sv/daily_alarm_table_scheduler_top_test.sv
`timescale 1ns / 1ps

module daily_alarm_table_scheduler_top_test;
    import dats_pkg::*;

    localparam int MEALS       = 8;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_ITEMS = 212;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              req_valid = 1'b0;
    t_req              req_data  = '0;
    logic              req_stall;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    t_rsp              rsp_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    t_entry      alarm_table [MEALS];
    logic [7:0]  served_bits;
    logic [4:0]  served_day;
    logic [3:0]  cfg_meal_count;
    logic [10:0] cfg_window;
    logic [15:0] cfg_max_seconds;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_go       = 1'b0;
    int   hold_left     = 0;
    int   error_count   = 0;
    int   time_pool [8];

    daily_alarm_table_scheduler_top #(
        .MAX_MEALS(MEALS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req_data),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_rsp found_entry(input int idx);
        t_rsp o;
        o              = '0;
        o.found        = 1'b1;
        o.meal_index   = 3'(idx);
        o.meal_hour    = alarm_table[idx].hour;
        o.meal_minute  = alarm_table[idx].minute;
        o.meal_grams   = alarm_table[idx].grams;
        o.meal_seconds = alarm_table[idx].seconds;
        return o;
    endfunction

    function automatic void roll_served_day(input logic [4:0] day);
        if (day != served_day) begin
            served_day  = day;
            served_bits = '0;
        end
    endfunction

    function automatic int entry_minutes(input int idx);
        return int'(alarm_table[idx].hour) * int'(MIN_PER_HOUR) + int'(alarm_table[idx].minute);
    endfunction

    function automatic t_rsp predict_response(input t_req r);
        t_rsp o;
        int   n;
        int   now_min;
        int   gap;
        int   best;
        int   best_dist;
        o         = '0;
        n         = (cfg_meal_count > MEALS) ? MEALS : int'(cfg_meal_count);
        now_min   = int'(r.hour) * int'(MIN_PER_HOUR) + int'(r.minute);
        best      = -1;
        best_dist = 100000;
        case (r.kind)
            KIND_WRITE: begin
                if (r.entry_index >= MEALS) begin
                    o.status = ST_BAD_INDEX;
                end else if (r.hour > LAST_HOUR || r.minute > LAST_MINUTE) begin
                    o.status = ST_BAD_TIME;
                end else if (r.grams == 0 && r.seconds == 0) begin
                    o.status = ST_NO_AMOUNT;
                end else if (r.grams > MAX_GRAMS) begin
                    o.status = ST_GRAMS_HIGH;
                end else if (r.seconds > cfg_max_seconds) begin
                    o.status = ST_SECONDS_HIGH;
                end else begin
                    o.status = ST_OK;
                    alarm_table[r.entry_index[2:0]] = '{hour: r.hour, minute: r.minute,
                                                       grams: r.grams[8:0],
                                                       seconds: r.seconds};
                    served_bits = '0;
                    served_day  = '0;
                end
            end
            KIND_DUE: begin
                if (n != 0) begin
                    roll_served_day(r.day_of_month);
                    for (int i = 0; i < n; i++) begin
                        gap = now_min - entry_minutes(i);
                        if (!o.found && !served_bits[i] && gap >= 0
                                && gap <= int'(cfg_window)) begin
                            o = found_entry(i);
                        end
                    end
                end
            end
            KIND_NEXT: begin
                for (int i = 0; i < n; i++) begin
                    gap = entry_minutes(i) - now_min;
                    if (gap <= 0) begin
                        gap += int'(DAY_MINUTES);
                    end
                    if (gap < best_dist) begin
                        best_dist = gap;
                        best      = i;
                    end
                end
                if (best >= 0) begin
                    o = found_entry(best);
                end
            end
            default: begin
                if (r.entry_index >= MEALS) begin
                    o.status = ST_BAD_INDEX;
                end else begin
                    roll_served_day(r.day_of_month);
                    served_bits[r.entry_index[2:0]] = 1'b1;
                end
            end
        endcase
        return o;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) begin
                expected_rsps.push_back(predict_response(req_data));
            end
            if (!req_valid || !req_stall) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_data  <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: response with no request waiting, expected none, actual %h",
                             $time, rsp_data);
                    error_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    compare_field("status", want.status, rsp_data.status);
                    compare_field("found", want.found, rsp_data.found);
                    compare_field("meal_index", want.meal_index, rsp_data.meal_index);
                    compare_field("meal_hour", want.meal_hour, rsp_data.meal_hour);
                    compare_field("meal_minute", want.meal_minute, rsp_data.meal_minute);
                    compare_field("meal_grams", want.meal_grams, rsp_data.meal_grams);
                    compare_field("meal_seconds", want.meal_seconds, rsp_data.meal_seconds);
                end
            end
            rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic write_register(input logic [1:0] sel, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_MEAL_COUNT:  cfg_meal_count  = value[3:0];
            REG_WINDOW:      cfg_window      = value[10:0];
            REG_MAX_SECONDS: cfg_max_seconds = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int count, input int window, input int max_sec);
        write_register(REG_MEAL_COUNT, 32'(count));
        write_register(REG_WINDOW, 32'(window));
        write_register(REG_MAX_SECONDS, 32'(max_sec));
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic push_req(input t_kind k, input int idx, input int hr, input int mn,
                            input int gr, input int sc, input int day);
        t_req r;
        r.kind         = k;
        r.entry_index  = 4'(idx);
        r.hour         = 5'(hr);
        r.minute       = 6'(mn);
        r.grams        = 10'(gr);
        r.seconds      = 16'(sc);
        r.day_of_month = 5'(day);
        pending_reqs.push_back(r);
    endtask

    function automatic t_req random_req(input logic [4:0] day_now);
        t_req        r;
        logic [63:0] noise;
        int          roll;
        int          at_min;
        noise = {$urandom, $urandom};
        r     = noise[47:0];
        if ($urandom_range(0, 99) < 80) begin
            roll           = $urandom_range(0, 9);
            at_min         = time_pool[$urandom_range(0, 7)];
            r.entry_index  = 4'($urandom_range(0, MEALS - 1));
            r.day_of_month = ($urandom_range(0, 5) == 0) ? day_now + 5'd1 : day_now;
            if (roll < 3) begin
                r.kind = KIND_WRITE;
                if ($urandom_range(0, 3) == 0) begin
                    at_min = $urandom_range(0, int'(DAY_MINUTES) - 1);
                end
                r.grams   = ($urandom_range(0, 9) == 0) ? 10'd0
                                                        : 10'($urandom_range(1, MAX_GRAMS));
                r.seconds = 16'($urandom_range(0, cfg_max_seconds));
            end else if (roll < 8) begin
                r.kind = (roll < 6) ? KIND_DUE : KIND_NEXT;
                at_min = (at_min + $urandom_range(0, 30)) % int'(DAY_MINUTES);
            end else begin
                r.kind = KIND_MARK;
            end
            r.hour   = 5'(at_min / int'(MIN_PER_HOUR));
            r.minute = 6'(at_min % int'(MIN_PER_HOUR));
        end
        return r;
    endfunction

    initial begin
        logic [4:0] day_now;
        for (int i = 0; i < MEALS; i++) begin
            alarm_table[i] = '0;
        end
        served_bits     = '0;
        served_day      = '0;
        cfg_meal_count  = MEAL_COUNT_RST;
        cfg_window      = WINDOW_RST;
        cfg_max_seconds = MAX_SECONDS_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_req(KIND_DUE, 0, 12, 0, 0, 0, 3);
        push_req(KIND_NEXT, 0, 31, 63, 0, 0, 0);
        push_req(KIND_WRITE, 15, 1, 1, 10, 1, 0);
        push_req(KIND_WRITE, 8, 1, 1, 10, 1, 0);
        push_req(KIND_WRITE, 0, 24, 0, 10, 1, 0);
        push_req(KIND_WRITE, 0, 23, 60, 10, 1, 0);
        push_req(KIND_WRITE, 0, 31, 63, 10, 1, 0);
        push_req(KIND_WRITE, 0, 6, 30, 0, 0, 0);
        push_req(KIND_WRITE, 0, 6, 30, 501, 0, 0);
        push_req(KIND_WRITE, 0, 6, 30, 1023, 65535, 0);
        push_req(KIND_WRITE, 0, 6, 30, 10, 61, 0);
        push_req(KIND_WRITE, 0, 6, 30, 0, 65535, 0);
        push_req(KIND_WRITE, 0, 23, 59, 500, 60, 0);
        push_req(KIND_WRITE, 7, 0, 0, 1, 0, 0);
        push_req(KIND_WRITE, 3, 12, 0, 0, 1, 0);
        push_req(KIND_MARK, 15, 0, 0, 0, 0, 31);
        push_req(KIND_MARK, 7, 0, 0, 0, 0, 31);
        wait_drained();

        apply_settings(MEALS, 1439, 65535);
        push_req(KIND_WRITE, 1, 12, 0, 100, 5, 0);
        push_req(KIND_WRITE, 2, 12, 0, 200, 6, 0);
        push_req(KIND_DUE, 0, 23, 59, 0, 0, 31);
        push_req(KIND_MARK, 0, 0, 0, 0, 0, 31);
        push_req(KIND_DUE, 0, 23, 59, 0, 0, 31);
        push_req(KIND_DUE, 0, 23, 59, 0, 0, 4);
        push_req(KIND_NEXT, 0, 11, 59, 0, 0, 0);
        push_req(KIND_NEXT, 0, 23, 59, 0, 0, 0);
        push_req(KIND_NEXT, 0, 31, 63, 0, 0, 0);
        push_req(KIND_NEXT, 0, 0, 0, 0, 0, 0);
        wait_drained();

        day_now = 5'($urandom_range(0, 31));
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       apply_settings(MEALS, 15, 60);
                1:       apply_settings(MEALS, 1439, 65535);
                2:       apply_settings(0, 0, 0);
                3:       apply_settings(15, $urandom_range(0, 1439), $urandom_range(0, 65535));
                4:       apply_settings(3, 0, 500);
                default: apply_settings($urandom_range(0, 15), $urandom_range(0, 1439),
                                        $urandom_range(0, 65535));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 54;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 54;
                end
                default: begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            time_pool[0] = 0;
            time_pool[1] = int'(DAY_MINUTES) - 1;
            for (int i = 2; i < 8; i++) begin
                time_pool[i] = $urandom_range(0, int'(DAY_MINUTES) - 1);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 39) == 0) begin
                    day_now = day_now + 5'd1;
                end
                pending_reqs.push_back(random_req(day_now));
            end
            if (phase == 4) begin
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
